// File: hw/rtl/ir_line_position_estimator_assert.svh
// Assertion macros for the line position estimator.
// Uses clk and rst of the module that includes this header.
`ifndef IR_LINE_POSITION_ESTIMATOR_ASSERT_SVH
`define IR_LINE_POSITION_ESTIMATOR_ASSERT_SVH

// Checks a property at every rising clock edge outside reset.
`define LPE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks a property at every rising clock edge, reset included.
`define LPE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: hw/rtl/lpe_pkg.sv
// Shared types and constants of the line position estimator.
// No dependencies.
package lpe_pkg;

  localparam int LANES      = 7;
  localparam int CENTRE     = 3;
  localparam int FRAC_BITS  = 8;
  localparam int SAMPLE_W   = 10;
  localparam int WEIGHT_W   = 14;
  localparam int POS_W      = 22;
  localparam int INDEX_W    = 3;
  localparam int NORM_W     = 11;
  localparam int SUM_W      = 27;
  localparam int DEN_W      = 13;
  localparam int DIV_NW     = 36;
  localparam int DIV_DW     = 14;
  localparam int DIV_CNT_W  = 6;

  localparam logic [NORM_W-1:0] FULL_SCALE = 11'd1000;

  typedef struct packed {
    logic                     start;
    logic signed [DIV_NW-1:0] dividend;
    logic signed [DIV_DW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                     busy;
    logic                     done;
    logic signed [DIV_NW-1:0] quotient;
  } div_rsp_t;

endpackage

// File: hw/rtl/lpe_if.sv
// Handshake channels of the line position estimator: frame, result and register write.
// Depends on lpe_pkg.
interface lpe_frame_if;
  logic                            valid;
  logic                            ready;
  logic                            kind;
  logic [lpe_pkg::SAMPLE_W-1:0]    sample_0;
  logic [lpe_pkg::SAMPLE_W-1:0]    sample_1;
  logic [lpe_pkg::SAMPLE_W-1:0]    sample_2;
  logic [lpe_pkg::SAMPLE_W-1:0]    sample_3;
  logic [lpe_pkg::SAMPLE_W-1:0]    sample_4;
  logic [lpe_pkg::SAMPLE_W-1:0]    sample_5;
  logic [lpe_pkg::SAMPLE_W-1:0]    sample_6;
  modport source (output valid, kind, sample_0, sample_1, sample_2, sample_3, sample_4,
                  sample_5, sample_6, input ready);
  modport sink (input valid, kind, sample_0, sample_1, sample_2, sample_3, sample_4,
                sample_5, sample_6, output ready);
endinterface

interface lpe_result_if;
  logic                             valid;
  logic                             ready;
  logic signed [lpe_pkg::POS_W-1:0] line_position;
  logic signed [lpe_pkg::POS_W-1:0] left_position;
  logic signed [lpe_pkg::POS_W-1:0] right_position;
  logic                             line_valid;
  logic                             left_valid;
  logic                             right_valid;
  modport source (output valid, line_position, left_position, right_position, line_valid,
                  left_valid, right_valid, input ready);
  modport sink (input valid, line_position, left_position, right_position, line_valid,
                left_valid, right_valid, output ready);
endinterface

interface lpe_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [lpe_pkg::INDEX_W-1:0]         index;
  logic signed [lpe_pkg::WEIGHT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/lpe_divider.sv
// Shared signed divider, restoring, one quotient bit per cycle, truncating toward zero.
// Depends on lpe_pkg.
module lpe_divider (
  input  logic              clk,
  input  logic              rst,
  input  lpe_pkg::div_req_t req,
  output lpe_pkg::div_rsp_t rsp
);

  logic                             busy;
  logic                             done;
  logic                             neg;
  logic [lpe_pkg::DIV_CNT_W-1:0]    count;
  logic [lpe_pkg::DIV_NW-1:0]       acc;
  logic [lpe_pkg::DIV_DW-1:0]       rem;
  logic [lpe_pkg::DIV_DW-1:0]       dmag;
  logic [lpe_pkg::DIV_DW:0]         trial;
  logic                             qbit;

  assign trial = {rem, acc[lpe_pkg::DIV_NW-1]};
  assign qbit  = (trial >= {1'b0, dmag});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= lpe_pkg::DIV_CNT_W'(lpe_pkg::DIV_NW - 1);
        neg   <= req.dividend[lpe_pkg::DIV_NW-1] ^ req.divisor[lpe_pkg::DIV_DW-1];
        acc   <= req.dividend[lpe_pkg::DIV_NW-1] ? (~req.dividend + 1'b1) : req.dividend;
        dmag  <= req.divisor[lpe_pkg::DIV_DW-1] ? (~req.divisor + 1'b1) : req.divisor;
        rem   <= '0;
      end else if (busy) begin
        rem <= qbit ? lpe_pkg::DIV_DW'(trial - {1'b0, dmag}) : trial[lpe_pkg::DIV_DW-1:0];
        acc <= {acc[lpe_pkg::DIV_NW-2:0], qbit};
        if (count == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          count <= count - 1'b1;
        end
      end
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = neg ? $signed(~acc + 1'b1) : $signed(acc);

endmodule

// File: hw/rtl/ir_line_position_estimator.sv
// Top level of the infrared line position estimator.
// Depends on lpe_pkg, lpe_if.sv, lpe_divider and ir_line_position_estimator_assert.svh.
// A calibration frame widens the per-sensor minima and maxima; the sequencer stays idle.
// A measure frame runs SENSOR_COUNT normalising divisions and three centroid divisions
// through one shared 36-bit divider that gives one quotient bit per cycle. Each sensor
// passes through NORM_START, NORM_WAIT for its quotient and ACCUM for its
// multiply-accumulate, each centroid through CENT_START and CENT_WAIT. The frame ends
// in FINISH, which loads the result register once that register is free or emptied.
// A sensor with equal minimum and maximum skips its division and goes straight to
// ACCUM; a centroid with a zero sum skips its division. The frame channel is not ready
// while a frame is in work; a finished result waits in the output register while the
// next frame is taken.
`include "ir_line_position_estimator_assert.svh"

module ir_line_position_estimator #(
  parameter int SENSOR_COUNT = 7
) (
  input logic        clk,
  input logic        rst,
  lpe_frame_if.sink  frame,
  lpe_result_if.source result,
  lpe_cfg_if.sink    cfg
);

  typedef enum logic [2:0] {
    IDLE, NORM_START, NORM_WAIT, ACCUM, CENT_START, CENT_WAIT, FINISH
  } state_t;

  state_t state;

  logic [lpe_pkg::SAMPLE_W-1:0]        sensor_minimum [lpe_pkg::LANES];
  logic [lpe_pkg::SAMPLE_W-1:0]        sensor_maximum [lpe_pkg::LANES];
  logic [lpe_pkg::SAMPLE_W-1:0]        sample         [lpe_pkg::LANES];
  logic [lpe_pkg::SAMPLE_W-1:0]        frame_sample   [lpe_pkg::LANES];
  logic signed [lpe_pkg::WEIGHT_W-1:0] weight         [lpe_pkg::LANES];

  logic [lpe_pkg::INDEX_W-1:0]       lane;
  logic [1:0]                        cent;
  logic [lpe_pkg::NORM_W-1:0]        norm;
  logic signed [lpe_pkg::SUM_W-1:0]  all_num, left_num, right_num;
  logic [lpe_pkg::DEN_W-1:0]         all_den, left_den, right_den;
  logic signed [lpe_pkg::POS_W-1:0]  pos [3];
  logic                              pos_ok [3];

  lpe_pkg::div_req_t div_req;
  lpe_pkg::div_rsp_t div_rsp;

  logic signed [lpe_pkg::NORM_W-1:0]   span;
  logic signed [lpe_pkg::NORM_W-1:0]   offset;
  logic signed [22:0]                  norm_num;
  logic signed [lpe_pkg::SUM_W-1:0]    cent_num;
  logic [lpe_pkg::DEN_W-1:0]           cent_den;
  logic signed [lpe_pkg::SUM_W-1:0]    product;
  logic                                is_left, is_right, last_lane;

  assign frame_sample[0] = frame.sample_0;
  assign frame_sample[1] = frame.sample_1;
  assign frame_sample[2] = frame.sample_2;
  assign frame_sample[3] = frame.sample_3;
  assign frame_sample[4] = frame.sample_4;
  assign frame_sample[5] = frame.sample_5;
  assign frame_sample[6] = frame.sample_6;

  assign span     = $signed({1'b0, sensor_maximum[lane]}) - $signed({1'b0, sensor_minimum[lane]});
  assign offset   = $signed({1'b0, sample[lane]}) - $signed({1'b0, sensor_minimum[lane]});
  assign norm_num = offset * $signed(-12'sd1000);
  assign product  = lpe_pkg::SUM_W'($signed({1'b0, norm}) * weight[lane]);
  assign is_left  = (lane < lpe_pkg::INDEX_W'(lpe_pkg::CENTRE));
  assign is_right = (lane > lpe_pkg::INDEX_W'(lpe_pkg::CENTRE));
  assign last_lane = (lane == lpe_pkg::INDEX_W'(SENSOR_COUNT - 1));

  always_comb begin
    case (cent)
      2'd0:    begin cent_num = all_num;   cent_den = all_den;   end
      2'd1:    begin cent_num = left_num;  cent_den = left_den;  end
      default: begin cent_num = right_num; cent_den = right_den; end
    endcase
  end

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    if (state == NORM_START) begin
      div_req.start    = (span != '0);
      div_req.dividend = lpe_pkg::DIV_NW'(norm_num);
      div_req.divisor  = lpe_pkg::DIV_DW'(span);
    end else if (state == CENT_START) begin
      div_req.start    = (cent_den != '0);
      div_req.dividend = {cent_num[lpe_pkg::SUM_W-1], cent_num, {lpe_pkg::FRAC_BITS{1'b0}}};
      div_req.divisor  = $signed({1'b0, cent_den});
    end
  end

  lpe_divider u_divider (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign frame.ready = (state == IDLE);
  assign cfg.ready   = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      result.valid <= 1'b0;
      for (int k = 0; k < lpe_pkg::LANES; k++) begin
        sensor_minimum[k] <= '1;
        sensor_maximum[k] <= '0;
        weight[k]         <= lpe_pkg::WEIGHT_W'((k - lpe_pkg::CENTRE) * 1000);
      end
    end else begin
      if (cfg.valid && (cfg.index < lpe_pkg::INDEX_W'(lpe_pkg::LANES))) begin
        weight[cfg.index] <= cfg.data;
      end
      // In FINISH the result register is refilled instead.
      if (result.valid && result.ready && (state != FINISH)) begin
        result.valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (frame.valid) begin
            if (frame.kind) begin
              for (int k = 0; k < SENSOR_COUNT; k++) begin
                if (frame_sample[k] < sensor_minimum[k]) sensor_minimum[k] <= frame_sample[k];
                if (frame_sample[k] > sensor_maximum[k]) sensor_maximum[k] <= frame_sample[k];
              end
            end else begin
              for (int k = 0; k < lpe_pkg::LANES; k++) sample[k] <= frame_sample[k];
              lane      <= '0;
              all_num   <= '0;
              left_num  <= '0;
              right_num <= '0;
              all_den   <= '0;
              left_den  <= '0;
              right_den <= '0;
              state     <= NORM_START;
            end
          end
        end
        NORM_START: begin
          if (span == '0) begin
            norm  <= '0;
            state <= ACCUM;
          end else begin
            state <= NORM_WAIT;
          end
        end
        NORM_WAIT: begin
          if (div_rsp.done) begin
            // Saturate 1000 + quotient to the range 0 to 1000.
            if (div_rsp.quotient > 0) begin
              norm <= lpe_pkg::FULL_SCALE;
            end else if (div_rsp.quotient < -1000) begin
              norm <= '0;
            end else begin
              norm <= lpe_pkg::NORM_W'(div_rsp.quotient + 1000);
            end
            state <= ACCUM;
          end
        end
        ACCUM: begin
          all_num <= all_num + product;
          all_den <= all_den + lpe_pkg::DEN_W'(norm);
          if (is_left) begin
            left_num <= left_num + product;
            left_den <= left_den + lpe_pkg::DEN_W'(norm);
          end
          if (is_right) begin
            right_num <= right_num + product;
            right_den <= right_den + lpe_pkg::DEN_W'(norm);
          end
          if (last_lane) begin
            cent  <= 2'd0;
            state <= CENT_START;
          end else begin
            lane  <= lane + 1'b1;
            state <= NORM_START;
          end
        end
        CENT_START: begin
          if (cent_den == '0) begin
            pos[cent]    <= '0;
            pos_ok[cent] <= 1'b0;
            if (cent == 2'd2) state <= FINISH;
            else cent <= cent + 1'b1;
          end else begin
            state <= CENT_WAIT;
          end
        end
        CENT_WAIT: begin
          if (div_rsp.done) begin
            pos[cent]    <= div_rsp.quotient[lpe_pkg::POS_W-1:0];
            pos_ok[cent] <= 1'b1;
            if (cent == 2'd2) begin
              state <= FINISH;
            end else begin
              cent  <= cent + 1'b1;
              state <= CENT_START;
            end
          end
        end
        FINISH: begin
          // The result register must be free or be emptied in this cycle.
          if (!result.valid || result.ready) begin
            result.valid          <= 1'b1;
            result.line_position  <= pos[0];
            result.left_position  <= pos[1];
            result.right_position <= pos[2];
            result.line_valid     <= pos_ok[0];
            result.left_valid     <= pos_ok[1];
            result.right_valid    <= pos_ok[2];
            state                 <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  `LPE_ASSERT(a_ready_not_dividing, frame.ready |-> !div_rsp.busy, "frame taken while divider busy")
  `LPE_ASSERT(a_done_when_waiting, div_rsp.done |-> (state == NORM_WAIT || state == CENT_WAIT), "divider result outside a wait state")
  `LPE_ASSERT(a_invalid_line_zero, (result.valid && !result.line_valid) |-> (result.line_position == '0), "invalid centroid not zero")
  `LPE_ASSERT_ALWAYS(a_reset_idle, rst |=> (state == IDLE && !result.valid), "reset did not clear the sequencer")

endmodule

// File: bench/lpe_testbench_if.sv
// Bench-side package with the frame and expected-centroid types of the line position bench.
// Depends on lpe_pkg; the channel interfaces themselves come from lpe_if.sv.
package lpe_tb_pkg;
  import lpe_pkg::*;

  typedef struct packed {
    logic                     kind;
    logic [6:0][SAMPLE_W-1:0] sample;
  } frame_t;

  typedef struct packed {
    logic signed [POS_W-1:0] line_pos;
    logic signed [POS_W-1:0] left_pos;
    logic signed [POS_W-1:0] right_pos;
    logic                    line_ok;
    logic                    left_ok;
    logic                    right_ok;
  } centroid_t;

  localparam logic KIND_MEASURE   = 1'b0;
  localparam logic KIND_CALIBRATE = 1'b1;
endpackage

// File: bench/testbench.sv
// Self-checking bench of the line position estimator: directed and random frames with
// weight changes, checked against a bit-true predictor. Depends on lpe_pkg, lpe_if.sv, lpe_tb_pkg.
module testbench;
  import lpe_pkg::*;
  import lpe_tb_pkg::*;

  localparam int DRAIN_CYCLES = 1000;
  localparam longint CYCLE_LIMIT = 64'd6000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  lpe_frame_if  frame();
  lpe_result_if result();
  lpe_cfg_if    cfg();

  ir_line_position_estimator #(.SENSOR_COUNT(7)) dut (
    .clk(clk), .rst(rst), .frame(frame), .result(result), .cfg(cfg)
  );

  logic signed [WEIGHT_W-1:0] weight [7];
  logic [SAMPLE_W-1:0] lowest [7];
  logic [SAMPLE_W-1:0] highest [7];
  centroid_t pending_centroids[$];
  int errors = 0;
  longint cycles = 0;
  int hold_off = 0;
  bit calm = 1'b0;

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  function automatic longint norm_value(logic [SAMPLE_W-1:0] s, logic [SAMPLE_W-1:0] lo,
                                        logic [SAMPLE_W-1:0] hi);
    longint d, v;
    d = longint'(hi) - longint'(lo);
    if (d == 0) return 0;
    v = (longint'(s) - longint'(lo)) * -1000 / d + 1000;
    if (v < 0) v = 0;
    if (v > 1000) v = 1000;
    return v;
  endfunction

  function automatic logic signed [POS_W-1:0] weighted_mean(longint num, longint den);
    longint q;
    if (den == 0) return '0;
    q = (num * 256) / den;
    return q[POS_W-1:0];
  endfunction

  // Updates calibration or returns 1 with the expected centroids.
  function automatic bit predict_frame(frame_t f, output centroid_t c);
    longint n, p, an, ad, ln, ld, rn, rd;
    an = 0; ad = 0; ln = 0; ld = 0; rn = 0; rd = 0;
    c = '0;
    if (f.kind == KIND_CALIBRATE) begin
      for (int i = 0; i < 7; i++) begin
        if (f.sample[i] < lowest[i]) lowest[i] = f.sample[i];
        if (f.sample[i] > highest[i]) highest[i] = f.sample[i];
      end
      return 1'b0;
    end
    for (int i = 0; i < 7; i++) begin
      n = norm_value(f.sample[i], lowest[i], highest[i]);
      p = n * longint'(weight[i]);
      an += p; ad += n;
      if (i < CENTRE) begin
        ln += p; ld += n;
      end else if (i > CENTRE) begin
        rn += p; rd += n;
      end
    end
    c.line_pos = weighted_mean(an, ad);  c.line_ok = (ad != 0);
    c.left_pos = weighted_mean(ln, ld);  c.left_ok = (ld != 0);
    c.right_pos = weighted_mean(rn, rd); c.right_ok = (rd != 0);
    return 1'b1;
  endfunction

  // Result side: random stalls plus an optional long hold-off.
  always @(posedge clk) begin
    centroid_t want, got;
    if (rst) begin
      result.ready <= 1'b0;
    end else begin
      if (result.valid && result.ready) begin
        got = '{result.line_position, result.left_position, result.right_position,
                result.line_valid, result.left_valid, result.right_valid};
        if (pending_centroids.size() == 0) begin
          errors++;
          $display("%0t: unexpected result %p", $time, got);
        end else begin
          want = pending_centroids.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: mismatch expected %p actual %p", $time, want, got);
          end
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        result.ready <= 1'b0;
      end else begin
        result.ready <= calm || ($urandom_range(99) >= 7);
      end
    end
  end

  // Leaves valid high after the accepting edge, so that the next request can follow at once;
  // an idle cycle or wait_idle drops it.
  task automatic send_frame(frame_t f);
    centroid_t c;
    while (!calm && $urandom_range(99) < 7) begin
      frame.valid <= 1'b0;
      @(posedge clk);
    end
    frame.valid <= 1'b1;
    frame.kind <= f.kind;
    {frame.sample_6, frame.sample_5, frame.sample_4, frame.sample_3, frame.sample_2,
     frame.sample_1, frame.sample_0} <= f.sample;
    @(posedge clk);
    while (!frame.ready) @(posedge clk);
    if (predict_frame(f, c)) pending_centroids.push_back(c);
  endtask

  task automatic wait_idle();
    frame.valid <= 1'b0;
    while (pending_centroids.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_weight(int idx, int value);
    cfg.valid <= 1'b1;
    cfg.index <= idx[INDEX_W-1:0];
    cfg.data <= value[WEIGHT_W-1:0];
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    if (idx < 7) weight[idx] = value[WEIGHT_W-1:0];
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic frame_t random_frame(logic kind, bit near_band);
    frame_t f;
    f.kind = kind;
    for (int i = 0; i < 7; i++)
      f.sample[i] = near_band ? SAMPLE_W'($urandom_range(900, 100)) : SAMPLE_W'($urandom);
    return f;
  endfunction

  task automatic test_uncalibrated();
    frame_t f;
    f.kind = KIND_MEASURE;
    f.sample = '0; send_frame(f);
    f.sample = '1; send_frame(f);
    send_frame(random_frame(KIND_MEASURE, 0));
    // Equal minimum and maximum after a single calibration frame.
    f.kind = KIND_CALIBRATE;
    for (int i = 0; i < 7; i++) f.sample[i] = SAMPLE_W'(500);
    send_frame(f);
    f.kind = KIND_MEASURE; send_frame(f);
    f.sample = '1; send_frame(f);
    wait_idle();
  endtask

  task automatic test_extremes();
    frame_t f;
    f.kind = KIND_CALIBRATE;
    f.sample = '0; send_frame(f);
    f.sample = '1; send_frame(f);
    f.kind = KIND_MEASURE;
    f.sample = '0; send_frame(f);
    f.sample = '1; send_frame(f);
    for (int i = 0; i < 7; i++) begin
      f.sample = '1; f.sample[i] = '0; send_frame(f);
    end
    // Only the centre sensor dark: left and right sums are zero.
    f.sample = '1; f.sample[3] = 10'd0; send_frame(f);
    wait_idle();
    for (int i = 0; i < 8; i++) write_weight(i, (i % 2) ? 4096 : -4096);
    f.sample = '0; send_frame(f);
    f.sample = {SAMPLE_W'(0), SAMPLE_W'(1023), SAMPLE_W'(0), SAMPLE_W'(1023), SAMPLE_W'(0),
                SAMPLE_W'(1023), SAMPLE_W'(0)};
    send_frame(f);
    wait_idle();
  endtask

  task automatic test_backpressure();
    calm = 1'b1;
    hold_off = 3000;
    for (int i = 0; i < 6; i++) send_frame(random_frame(KIND_MEASURE, 0));
    wait_idle();
    calm = 1'b0;
  endtask

  task automatic test_random(int count);
    for (int n = 0; n < count; n++) begin
      if (n % 400 == 0) begin
        wait_idle();
        for (int i = 0; i < 7; i++) write_weight(i, $urandom_range(8192) - 4096);
        write_weight($urandom_range(7), $urandom_range(8192) - 4096);
      end
      calm = (n % 400) >= 300 && (n % 400) < 360;
      if ($urandom_range(99) < 15) send_frame(random_frame(KIND_CALIBRATE, $urandom_range(1)));
      else send_frame(random_frame(KIND_MEASURE, $urandom_range(3) != 0));
    end
    calm = 1'b0;
  endtask

  initial begin
    frame.valid = 1'b0; frame.kind = 1'b0;
    {frame.sample_0, frame.sample_1, frame.sample_2, frame.sample_3, frame.sample_4,
     frame.sample_5, frame.sample_6} = '0;
    cfg.valid = 1'b0; cfg.index = '0; cfg.data = '0;
    weight = '{-3000, -2000, -1000, 0, 1000, 2000, 3000};
    for (int i = 0; i < 7; i++) begin
      lowest[i] = 10'd1023;
      highest[i] = 10'd0;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_uncalibrated();
    test_extremes();
    test_backpressure();
    test_random(1600);
    wait_idle();
    if (errors == 0 && pending_centroids.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end
endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/lpe_pkg.sv
hw/rtl/lpe_if.sv
hw/rtl/lpe_divider.sv
hw/rtl/ir_line_position_estimator.sv
bench/lpe_testbench_if.sv
bench/testbench.sv
